FILE: hw/rtl/motion_envelope_sine_oscillator_defines.svh
// assertion macros for the motion envelope sine oscillator
// no dependencies
`ifndef MOTION_ENVELOPE_SINE_OSCILLATOR_DEFINES_SVH
`define MOTION_ENVELOPE_SINE_OSCILLATOR_DEFINES_SVH

// a clocked implication with reset guard
`define MESO_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// a next-cycle implication with reset guard
`define MESO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/meso_pkg.sv
// shared types, constants and the sine polynomial for the motion oscillator
// no dependencies
package meso_pkg;

   localparam int AXES_DEF = 3;
   localparam int SINE_BITS_DEF = 10;

   localparam logic [2:0] REG_DC_POLE   = 3'd0;
   localparam logic [2:0] REG_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_ROLLOFF   = 3'd2;
   localparam logic [2:0] REG_FREQ_LOW  = 3'd3;
   localparam logic [2:0] REG_FREQ_HIGH = 3'd4;
   localparam logic [2:0] REG_SPAN      = 3'd5;
   localparam logic [2:0] REG_AMPLITUDE = 3'd6;
   localparam logic [2:0] REG_PHASE_HZ  = 3'd7;

   localparam logic signed [26:0] Y_MAX = 27'sd67108863;
   localparam logic signed [26:0] Y_MIN = -27'sd67108864;
   localparam logic [26:0] OUT_MAX = 27'd134217727;
   localparam logic [14:0] FREQ_MAX = 15'd24000;
   localparam logic [31:0] ONE_Q30 = 32'd1073741824;

   localparam logic [31:0] SIN_C0 = 32'd1686629713;
   localparam logic [31:0] SIN_C1 = 32'd693598668;
   localparam logic [31:0] SIN_C2 = 32'd85569306;
   localparam logic [31:0] SIN_C3 = 32'd5027000;
   localparam logic [31:0] SIN_C4 = 32'd172271;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AXES,
      ST_ROOT,
      ST_DIV,
      ST_SINE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [15:0] dc_pole;
      logic [23:0] motion_threshold;
      logic [23:0] peak_rolloff;
      logic [14:0] freq_low_hz;
      logic [14:0] freq_high_hz;
      logic [26:0] motion_span;
      logic [15:0] tone_amplitude;
      logic [31:0] phase_per_hz;
   } cfg_type;

   // horner coefficient by index, c0 the lowest power
   function automatic logic [31:0] sin_coef(input logic [2:0] k);
      logic [31:0] c;
      unique case (k)
         3'd0: c = SIN_C0;
         3'd1: c = SIN_C1;
         3'd2: c = SIN_C2;
         3'd3: c = SIN_C3;
         default: c = SIN_C4;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/meso_if.sv
// valid/ready channel interfaces for the motion oscillator
// no dependencies
interface meso_req_if;
   logic        valid;
   logic        ready;
   logic        has_sample;
   logic [15:0] accel_x;
   logic [15:0] accel_y;
   logic [15:0] accel_z;
   modport source (output valid, has_sample, accel_x, accel_y, accel_z, input ready);
   modport sink (input valid, has_sample, accel_x, accel_y, accel_z, output ready);
endinterface

interface meso_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] tone_sample;
   logic [26:0]        motion_level;
   logic [26:0]        peak_level;
   logic [14:0]        tone_freq_hz;
   modport source (output valid, tone_sample, motion_level, peak_level, tone_freq_hz,
                   input ready);
   modport sink (input valid, tone_sample, motion_level, peak_level, tone_freq_hz,
                 output ready);
endinterface

interface meso_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/meso_lane.sv
// one axis dc blocker lane: registered product then saturating add
// depends on meso_pkg
module meso_lane (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        commit,
   input  logic [15:0] x,
   input  logic [15:0] dc_pole,
   output logic [52:0] y_sq
);
   localparam logic signed [28:0] Y_MAX_EXT = 29'(meso_pkg::Y_MAX);
   localparam logic signed [28:0] Y_MIN_EXT = 29'(meso_pkg::Y_MIN);

   logic [15:0]        prev_in_ff;
   logic signed [26:0] prev_out_ff;
   logic signed [43:0] prod_ff, prod_in;
   logic signed [26:0] y_ff, y_in;
   logic [52:0]        sq_ff;
   logic signed [53:0] sq_full;
   logic signed [28:0] sum;
   logic signed [27:0] fb;

   assign prod_in = $signed({1'b0, dc_pole}) * prev_out_ff;
   // arithmetic shift is floor division by 2^16
   assign fb  = 28'(prod_ff >>> 16);
   assign sum = 29'($signed({1'b0, x}) - $signed({1'b0, prev_in_ff})) * 29'sd256
                + 29'(fb);
   always_comb begin
      priority if (sum > Y_MAX_EXT) y_in = meso_pkg::Y_MAX;
      else if (sum < Y_MIN_EXT) y_in = meso_pkg::Y_MIN;
      else y_in = sum[26:0];
   end
   assign sq_full = y_ff * y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_in_ff  <= '0;
         prev_out_ff <= '0;
      end else if (commit) begin
         prev_in_ff  <= x;
         prev_out_ff <= y_ff;
      end
      if (start) prod_ff <= prod_in;
      y_ff  <= y_in;
      sq_ff <= sq_full[52:0];
   end
   assign y_sq = sq_ff;
endmodule

FILE: hw/rtl/meso_merge.sv
// merge stage: sum of lane squares, bit-serial square root, map, peak follower
// depends on meso_pkg
module meso_merge #(
   parameter int AXES = meso_pkg::AXES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   step_root,
   input  logic                   step_div,
   input  logic                   finish,
   input  logic [AXES-1:0][52:0]  sq,
   input  meso_pkg::cfg_type      cfg,
   output logic [26:0]            motion_level,
   output logic [26:0]            peak_level,
   output logic [14:0]            freq_hz
);
   logic [54:0] rem_ff, rem_in;
   logic [27:0] root_ff, root_in;
   logic [26:0] raw;
   logic [54:0] total;
   logic [16:0] diff_mag;
   logic        neg_ff;
   logic [43:0] num_ff;
   logic [43:0] quo_ff;
   logic [44:0] drem_ff, drem_next;
   logic [43:0] scaled;
   logic [26:0] span;
   logic [26:0] motion_ff, peak_ff, motion_in, peak_in, pk;
   logic [14:0] freq_ff;
   logic signed [45:0] fsum;
   logic signed [16:0] diff;
   logic        div_start;

   always_comb begin
      total = '0;
      for (int j = 0; j < AXES; j++) total = total + 55'(sq[j]);
   end

   // restoring square root, two radicand bits a step
   logic [55:0] trial;
   logic [56:0] rem_sh;
   assign rem_sh = {rem_ff[54:0], 2'b00} | 57'(num_ff[43:42]);
   assign trial  = {root_ff[26:0], 2'b01} ;
   always_comb begin
      if (rem_sh >= 57'(trial)) begin
         rem_in  = 55'(rem_sh - 57'(trial));
         root_in = {root_ff[26:0], 1'b1};
      end else begin
         rem_in  = 55'(rem_sh);
         root_in = {root_ff[26:0], 1'b0};
      end
   end
   assign raw = root_ff > 28'(meso_pkg::OUT_MAX) ? meso_pkg::OUT_MAX : root_ff[26:0];

   assign diff = $signed({2'b0, cfg.freq_high_hz}) - $signed({2'b0, cfg.freq_low_hz});
   assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
   assign span = cfg.motion_span == '0 ? 27'd1 : cfg.motion_span;
   assign drem_next = {drem_ff[43:0], num_ff[43]};
   assign scaled = diff_mag * raw;

   // the sequencer raises both steps for one cycle after the last root step
   assign div_start = step_root && step_div;

   always_ff @(posedge clock) begin
      if (load) begin
         // 56-bit radicand: num_ff holds the top 44 bits, quo_ff the low 12 while rooting
         rem_ff  <= '0;
         root_ff <= '0;
         num_ff  <= {1'b0, total[54:12]};
         quo_ff  <= {32'd0, total[11:0]};
      end else if (div_start) begin
         neg_ff  <= diff[16];
         num_ff  <= scaled;
         drem_ff <= '0;
         quo_ff  <= '0;
      end else if (step_root) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         num_ff  <= {num_ff[41:0], quo_ff[11:10]};
         quo_ff  <= {quo_ff[43:12], quo_ff[9:0], 2'b00};
      end else if (step_div) begin
         if (drem_next >= 45'(span)) begin
            drem_ff <= drem_next - 45'(span);
            quo_ff  <= {quo_ff[42:0], 1'b1};
         end else begin
            drem_ff <= drem_next;
            quo_ff  <= {quo_ff[42:0], 1'b0};
         end
         num_ff <= {num_ff[42:0], 1'b0};
      end
   end

   assign fsum = $signed({31'd0, cfg.freq_low_hz})
                 + (neg_ff ? -$signed({2'b0, quo_ff}) : $signed({2'b0, quo_ff}));
   assign motion_in = raw > 27'(cfg.motion_threshold) ?
                      raw - 27'(cfg.motion_threshold) : '0;
   assign pk = motion_in > peak_ff ? motion_in : peak_ff;
   assign peak_in = pk > 27'(cfg.peak_rolloff) ? pk - 27'(cfg.peak_rolloff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff <= '0;
         peak_ff   <= '0;
         freq_ff   <= 15'd50;
      end else if (finish) begin
         motion_ff <= motion_in;
         peak_ff   <= peak_in;
         if (fsum < 0) freq_ff <= '0;
         else if (fsum > 46'(meso_pkg::FREQ_MAX)) freq_ff <= meso_pkg::FREQ_MAX;
         else freq_ff <= fsum[14:0];
      end
   end
   assign motion_level = motion_ff;
   assign peak_level   = peak_ff;
   assign freq_hz      = freq_ff;
endmodule

FILE: hw/rtl/meso_sine.sv
// sine unit: one product register walks the horner steps, then amplitude scale
// depends on meso_pkg
module meso_sine #(
   parameter int SINE_TABLE_BITS = meso_pkg::SINE_BITS_DEF
) (
   input  logic               clock,
   input  logic               start,
   input  logic               step,
   input  logic [31:0]        phase,
   input  logic [15:0]        amplitude,
   output logic signed [15:0] sample
);
   localparam int QB = SINE_TABLE_BITS - 2;
   localparam logic [QB:0] N = (QB+1)'(1) << QB;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [1:0]   quad;
   logic [QB:0]  pos;
   logic [31:0]  t_ff, t2_ff, s_ff;
   logic [63:0]  prod_ff;
   logic [2:0]   k_ff;
   logic [1:0]   quad_ff;
   logic [31:0]  sc;
   logic [31:0]  hs;
   logic [15:0]  mag;

   assign idx  = phase[31 -: SINE_TABLE_BITS];
   assign quad = idx[SINE_TABLE_BITS-1 -: 2];
   assign pos  = quad[0] ? N - (QB+1)'(idx[QB-1:0]) : (QB+1)'(idx[QB-1:0]);
   assign sc   = s_ff > meso_pkg::ONE_Q30 ? meso_pkg::ONE_Q30 : s_ff;
   assign mag  = 16'((64'(amplitude) * 64'(sc)) >> 31);
   assign hs   = meso_pkg::sin_coef(k_ff - 3'd3) - 32'(prod_ff >> 30);

   // k_ff: 7 computes t2, 6..3 horner, 2 final t product, 1 hold
   always_ff @(posedge clock) begin
      if (start) begin
         t_ff    <= 32'(pos) << (30 - QB);
         quad_ff <= quad;
         k_ff    <= 3'd7;
         s_ff    <= meso_pkg::SIN_C4;
         prod_ff <= 64'(32'(pos) << (30 - QB)) * 64'(32'(pos) << (30 - QB));
      end else if (step) begin
         unique case (k_ff)
            3'd7: begin
               t2_ff   <= 32'(prod_ff >> 30);
               prod_ff <= 64'(32'(prod_ff >> 30)) * 64'(s_ff);
               k_ff    <= 3'd6;
            end
            3'd6, 3'd5, 3'd4, 3'd3: begin
               s_ff <= hs;
               if (k_ff == 3'd3) prod_ff <= 64'(t_ff) * 64'(hs);
               else prod_ff <= 64'(t2_ff) * 64'(hs);
               k_ff <= k_ff - 3'd1;
            end
            3'd2: begin
               s_ff <= 32'(prod_ff >> 30);
               k_ff <= 3'd1;
            end
            default: k_ff <= k_ff;
         endcase
      end
   end
   assign sample = quad_ff[1] ? 16'(-mag) : mag;
endmodule

FILE: hw/rtl/motion_envelope_sine_oscillator.sv
// channel    | dir | payload
// req_       | in  | has_sample, accel_x/y/z
// rsp_       | out | tone_sample, motion_level, peak_level, tone_freq_hz
// csr_       | in  | index, data
// a frame with a sample passes after accept through the lanes, the root steps, the divide
// start, the divide steps and the finish, then the sine steps, and gives its beat
// a frame without one goes from accept straight to the sine steps before its beat
// one frame at a time; req_ready is low from accept until idle, after its beat leaves rsp_
// reset is synchronous and restores register defaults, control, phase, filters, levels, freq
// depends on meso_pkg, meso_if, meso_lane, meso_merge, meso_sine
module motion_envelope_sine_oscillator #(
   parameter int AXES = meso_pkg::AXES_DEF,
   parameter int SINE_TABLE_BITS = meso_pkg::SINE_BITS_DEF
) (
   input logic clock,
   input logic reset,
   meso_req_if.sink   req,
   meso_rsp_if.source rsp,
   meso_csr_if.sink   csr
);
   meso_pkg::cfg_type   cfg_ff;
   meso_pkg::state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] phase_ff;
   logic [15:0] ax_ff [3];
   logic [AXES-1:0][52:0] sq;
   logic lane_start, lane_commit, load, step_root, step_div, finish, sine_start, sine_step;
   logic [26:0] motion, peak;
   logic [14:0] freq;
   logic signed [15:0] tone;
   logic rsp_valid_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{16'd65523, 24'd168, 24'd487, 15'd50, 15'd800, 27'd8388608,
                     16'd52429, 32'd97392};
      end else if (csr.valid) begin
         unique case (csr.index)
            meso_pkg::REG_DC_POLE:   cfg_ff.dc_pole <= csr.data[15:0];
            meso_pkg::REG_THRESHOLD: cfg_ff.motion_threshold <= csr.data[23:0];
            meso_pkg::REG_ROLLOFF:   cfg_ff.peak_rolloff <= csr.data[23:0];
            meso_pkg::REG_FREQ_LOW:  cfg_ff.freq_low_hz <= csr.data[14:0];
            meso_pkg::REG_FREQ_HIGH: cfg_ff.freq_high_hz <= csr.data[14:0];
            meso_pkg::REG_SPAN:      cfg_ff.motion_span <= csr.data[26:0];
            meso_pkg::REG_AMPLITUDE: cfg_ff.tone_amplitude <= csr.data[15:0];
            meso_pkg::REG_PHASE_HZ:  cfg_ff.phase_per_hz <= csr.data;
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < AXES; g++) begin : g_lane
         meso_lane u_lane (
            .clock, .reset, .start(lane_start), .commit(lane_commit),
            .x(ax_ff[g]), .dc_pole(cfg_ff.dc_pole), .y_sq(sq[g])
         );
      end
   endgenerate

   meso_merge #(.AXES(AXES)) u_merge (
      .clock, .reset, .load, .step_root, .step_div, .finish, .sq, .cfg(cfg_ff),
      .motion_level(motion), .peak_level(peak), .freq_hz(freq)
   );

   meso_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
      .clock, .start(sine_start), .step(sine_step), .phase(phase_ff),
      .amplitude(cfg_ff.tone_amplitude), .sample(tone)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff + 6'd1;
      lane_start = 1'b0; lane_commit = 1'b0; load = 1'b0; step_root = 1'b0;
      step_div = 1'b0; finish = 1'b0; sine_start = 1'b0; sine_step = 1'b0;
      unique case (state_ff)
         meso_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req.valid) state_in = req.has_sample ? meso_pkg::ST_AXES : meso_pkg::ST_SINE;
         end
         meso_pkg::ST_AXES: begin
            lane_start = cnt_ff == 6'd0;
            if (cnt_ff == 6'd3) begin
               lane_commit = 1'b1; load = 1'b1; cnt_in = '0; state_in = meso_pkg::ST_ROOT;
            end
         end
         meso_pkg::ST_ROOT: begin
            step_root = 1'b1;
            // after 28 root steps, the following cycle loads the divide from the finished root
            if (cnt_ff == 6'd28) begin
               step_div = 1'b1; cnt_in = '0; state_in = meso_pkg::ST_DIV;
            end
         end
         meso_pkg::ST_DIV: begin
            if (cnt_ff == 6'd44) begin
               finish = 1'b1; cnt_in = '0; state_in = meso_pkg::ST_SINE;
            end else step_div = 1'b1;
         end
         meso_pkg::ST_SINE: begin
            if (cnt_ff == 6'd0) sine_start = 1'b1; else sine_step = 1'b1;
            if (cnt_ff == 6'd7) state_in = meso_pkg::ST_OUT;
         end
         default: begin
            if (!rsp_valid_ff) state_in = meso_pkg::ST_IDLE;
         end
      endcase
   end

   assign req.ready = state_ff == meso_pkg::ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= meso_pkg::ST_IDLE;
         cnt_ff <= '0;
         phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (state_ff == meso_pkg::ST_SINE && cnt_ff == 6'd7) begin
            rsp_valid_ff <= 1'b1;
            phase_ff <= phase_ff + 32'(freq * cfg_ff.phase_per_hz);
         end else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      if (req.valid && req.ready) begin
         ax_ff[0] <= req.accel_x; ax_ff[1] <= req.accel_y; ax_ff[2] <= req.accel_z;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.tone_sample = tone;
   assign rsp.motion_level = motion;
   assign rsp.peak_level = peak;
   assign rsp.tone_freq_hz = freq;
endmodule

FILE: hw/rtl/meso_checker.sv
// port-level checker for the motion oscillator, bound to the top level
// depends on meso_if and the defines header
`include "motion_envelope_sine_oscillator_defines.svh"
module meso_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [14:0] rsp_tone_freq_hz
);
   `MESO_ASSERT_IMPL(a_one_at_a_time, clock, reset, rsp_valid, !req_ready, "input taken while beat pending")
   `MESO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after accept")
   `MESO_ASSERT_IMPL(a_freq_range, clock, reset, rsp_valid, rsp_tone_freq_hz <= 15'd24000, "frequency out of range")
   `MESO_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "beat dropped while stalled")
endmodule

bind motion_envelope_sine_oscillator meso_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_tone_freq_hz(rsp.tone_freq_hz)
);

FILE: sim/testbench.sv
// self-checking testbench for motion_envelope_sine_oscillator: frames with and without
// accelerometer samples under several register settings, checked by a cycle-free predictor
// depends on meso_pkg, meso_if and the block's rtl
typedef struct {
   logic signed [15:0] tone;
   logic [26:0]        motion;
   logic [26:0]        peak;
   logic [14:0]        freq;
} tone_beat_type;

class tone_board;
   meso_pkg::cfg_type cfg;
   bit [15:0]     prev_in[3];
   longint        prev_out[3];
   bit [26:0]     motion_q;
   bit [26:0]     peak_q;
   bit [14:0]     freq_q;
   bit [31:0]     phase_q;
   tone_beat_type expected_beats[$];
   int            mismatches;

   function new();
      cfg.dc_pole          = 16'd65523;
      cfg.motion_threshold = 24'd168;
      cfg.peak_rolloff     = 24'd487;
      cfg.freq_low_hz      = 15'd50;
      cfg.freq_high_hz     = 15'd800;
      cfg.motion_span      = 27'd8388608;
      cfg.tone_amplitude   = 16'd52429;
      cfg.phase_per_hz     = 32'd97392;
      foreach (prev_in[j]) begin
         prev_in[j]  = '0;
         prev_out[j] = 0;
      end
      motion_q   = '0;
      peak_q     = '0;
      freq_q     = 15'd50;
      phase_q    = '0;
      mismatches = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
         meso_pkg::REG_DC_POLE:   cfg.dc_pole          = data[15:0];
         meso_pkg::REG_THRESHOLD: cfg.motion_threshold = data[23:0];
         meso_pkg::REG_ROLLOFF:   cfg.peak_rolloff     = data[23:0];
         meso_pkg::REG_FREQ_LOW:  cfg.freq_low_hz      = data[14:0];
         meso_pkg::REG_FREQ_HIGH: cfg.freq_high_hz     = data[14:0];
         meso_pkg::REG_SPAN:      cfg.motion_span      = data[26:0];
         meso_pkg::REG_AMPLITUDE: cfg.tone_amplitude   = data[15:0];
         default:                 cfg.phase_per_hz     = data;
      endcase
   endfunction

   function bit [63:0] int_root(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // odd polynomial for sin(pi/2*t), t in q1.30
   function bit [63:0] quarter_sine(bit [63:0] t);
      bit [63:0] c[5];
      bit [63:0] t2, s;
      c = '{meso_pkg::SIN_C0, meso_pkg::SIN_C1, meso_pkg::SIN_C2, meso_pkg::SIN_C3,
            meso_pkg::SIN_C4};
      t2 = (t * t) >> 30;
      s = c[4];
      for (int k = 3; k >= 0; k--) s = c[k] - ((t2 * s) >> 30);
      s = (t * s) >> 30;
      return (s > meso_pkg::ONE_Q30) ? 64'(meso_pkg::ONE_Q30) : s;
   endfunction

   function void blend_motion(bit [15:0] ax[3]);
      bit [63:0] sum, raw, span;
      longint    y, diff, f;
      sum = 0;
      for (int j = 0; j < 3; j++) begin
         y = (longint'(ax[j]) - longint'(prev_in[j])) * 256;
         y += (longint'(cfg.dc_pole) * prev_out[j]) >>> 16;
         if (y > 64'sd67108863) y = 64'sd67108863;
         if (y < -64'sd67108864) y = -64'sd67108864;
         prev_in[j]  = ax[j];
         prev_out[j] = y;
         sum += 64'(y * y);
      end
      raw = int_root(sum);
      if (raw > meso_pkg::OUT_MAX) raw = meso_pkg::OUT_MAX;
      span = (cfg.motion_span == 0) ? 64'd1 : 64'(cfg.motion_span);
      diff = longint'(cfg.freq_high_hz) - longint'(cfg.freq_low_hz);
      f = longint'(cfg.freq_low_hz) + (diff * longint'(raw)) / longint'(span);
      if (f < 0) f = 0;
      if (f > 24000) f = 24000;
      freq_q   = f[14:0];
      motion_q = (raw > cfg.motion_threshold) ? 27'(raw - cfg.motion_threshold) : '0;
      if (motion_q > peak_q) peak_q = motion_q;
      peak_q = (peak_q > cfg.peak_rolloff) ? 27'(peak_q - cfg.peak_rolloff) : '0;
   endfunction

   function void note_frame(bit has_sample, bit [15:0] ax[3]);
      tone_beat_type e;
      bit [31:0]  idx, quad, p, pos;
      bit [63:0]  mag;
      if (has_sample) blend_motion(ax);
      idx  = phase_q >> (32 - meso_pkg::SINE_BITS_DEF);
      quad = (idx >> (meso_pkg::SINE_BITS_DEF - 2)) & 3;
      p    = idx & ((1 << (meso_pkg::SINE_BITS_DEF - 2)) - 1);
      pos  = quad[0] ? (1 << (meso_pkg::SINE_BITS_DEF - 2)) - p : p;
      mag  = (64'(cfg.tone_amplitude) *
              quarter_sine(64'(pos) << (30 - (meso_pkg::SINE_BITS_DEF - 2)))) >> 31;
      e.tone   = (quad >= 2) ? 16'(16'h0 - mag[15:0]) : mag[15:0];
      e.motion = motion_q;
      e.peak   = peak_q;
      e.freq   = freq_q;
      expected_beats.push_back(e);
      phase_q = phase_q + 32'(64'(freq_q) * 64'(cfg.phase_per_hz));
   endfunction

   function void check_beat(tone_beat_type got);
      tone_beat_type e;
      if (expected_beats.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat: tone %0d", got.tone);
         return;
      end
      e = expected_beats.pop_front();
      if (got.tone !== e.tone || got.motion !== e.motion || got.peak !== e.peak ||
          got.freq !== e.freq) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result mismatch: expected tone %0d motion %0d peak %0d freq %0d,",
                     e.tone, e.motion, e.peak, e.freq,
                     " got tone %0d motion %0d peak %0d freq %0d",
                     got.tone, got.motion, got.peak, got.freq);
      end
   endfunction
endclass

module testbench;
   logic clock;
   logic reset;
   int   quiet_cycles;
   tone_board board;

   meso_req_if req_ch();
   meso_rsp_if rsp_ch();
   meso_csr_if csr_ch();

   motion_envelope_sine_oscillator u_top (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch)
   );

   always #6 clock = ~clock;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.has_sample = 1'b0;
      req_ch.accel_x = '0;
      req_ch.accel_y = '0;
      req_ch.accel_z = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = meso_pkg::REG_DC_POLE;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      board = new();
   end

   // result beats
   always @(posedge clock) begin
      tone_beat_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.tone   = rsp_ch.tone_sample;
         got.motion = rsp_ch.motion_level;
         got.peak   = rsp_ch.peak_level;
         got.freq   = rsp_ch.tone_freq_hz;
         board.check_beat(got);
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= 3000) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // receiver stalls, drawn per beat
   initial begin
      int k;
      @(negedge reset);
      forever begin
         k = $urandom_range(0, 5);
         repeat (k) @(negedge clock) rsp_ch.ready = 1'b0;
         @(negedge clock) rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // all driving tasks start and end at a falling edge
   task automatic send_frame(bit hs, bit [15:0] x, bit [15:0] y, bit [15:0] z);
      int        gap;
      bit [15:0] ax[3];
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.has_sample = hs;
      req_ch.accel_x = x;
      req_ch.accel_y = y;
      req_ch.accel_z = z;
      do @(posedge clock); while (!req_ch.ready);
      ax = '{x, y, z};
      board.note_frame(hs, ax);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data = data;
      do @(posedge clock); while (!csr_ch.ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic load_setting(logic [31:0] pole, logic [31:0] thr, logic [31:0] roll,
                               logic [31:0] flo, logic [31:0] fhi, logic [31:0] span,
                               logic [31:0] amp, logic [31:0] pph);
      req_ch.valid = 1'b0;
      while (board.expected_beats.size() != 0) @(negedge clock);
      write_reg(meso_pkg::REG_DC_POLE, pole);
      write_reg(meso_pkg::REG_THRESHOLD, thr);
      write_reg(meso_pkg::REG_ROLLOFF, roll);
      write_reg(meso_pkg::REG_FREQ_LOW, flo);
      write_reg(meso_pkg::REG_FREQ_HIGH, fhi);
      write_reg(meso_pkg::REG_SPAN, span);
      write_reg(meso_pkg::REG_AMPLITUDE, amp);
      write_reg(meso_pkg::REG_PHASE_HZ, pph);
   endtask

   function automatic bit [15:0] pick_axis();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_frames(int n);
      for (int i = 0; i < n; i++)
         send_frame($urandom_range(0, 9) < 7, pick_axis(), pick_axis(), pick_axis());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes under reset defaults, ignored fields on frames without sample
      send_frame(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_frame(1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_frame(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_frame(1'b0, 16'h1234, 16'h5678, 16'h9ABC);
      send_frame(1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_frame(1'b1, 16'hFFFF, 16'h0000, 16'h0000);
      send_frame(1'b1, 16'h0000, 16'hFFFF, 16'h0000);
      send_frame(1'b1, 16'h0000, 16'h0000, 16'hFFFF);
      send_frame(1'b1, 16'h8000, 16'h8000, 16'h8000);
      for (int i = 0; i < 6; i++) send_frame(1'b0, 16'hAAAA, 16'h5555, 16'hFFFF);
      load_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd24000, 32'd0, 32'hFFFF, 32'd1);
      send_frame(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_frame(1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_frame(1'b0, 16'h0000, 16'h0000, 16'h0000);
      random_frames(150);

      // above-range frequency registers, negative slope, widest span and step
      load_setting(32'hFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'h7FFF, 32'd0, 32'h7FFFFFF,
                   32'hFFFF, 32'hFFFFFFFF);
      random_frames(150);

      // tiny span drives the frequency to its clamp, phase frozen
      load_setting(32'hFFFF, 32'd16, 32'd8, 32'd0, 32'h7FFF, 32'd1, 32'd0, 32'd0);
      random_frames(120);

      load_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
      random_frames(150);

      load_setting(32'd60000, 32'd168, 32'd487, 32'd50, 32'd800, 32'd8388608,
                   32'd52429, $urandom);
      random_frames(200);

      req_ch.valid = 1'b0;
      while (board.expected_beats.size() != 0) @(negedge clock);
      repeat (100) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
